// ===== rtl/circle_span_rasterizer_assert.svh =====
// assertion macros for the circle span rasterizer
// used by the top level, expects clk and arst_n in scope
`ifndef CIRCLE_SPAN_RASTERIZER_ASSERT_SVH
`define CIRCLE_SPAN_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CRS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crs check failed: implication");

// next-cycle implication, checked out of reset
`define CRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crs check failed: next cycle");

`endif

// ===== rtl/crs_pkg.sv =====
// shared types and constants for the circle span rasterizer
// no dependencies
`timescale 1ns / 1ps

package crs_pkg;

	localparam int CENTER_W        = 16;
	localparam int COORD_W         = 17;
	localparam int OFF_MAX_W       = 16;
	localparam int RADIUS_BITS_DEF = 12;
	localparam int QUEUE_DEPTH     = 2;
	localparam int IDX_W           = 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [IDX_W-1:0] OUTLINE_LAST = 3'd7;
	localparam logic [IDX_W-1:0] FILL_LAST    = 3'd3;

	// one step of work handed from the front to the back
	typedef struct packed {
		logic signed [CENTER_W-1:0] cx;
		logic signed [CENTER_W-1:0] cy;
		logic [OFF_MAX_W-1:0]       ox;
		logic [OFF_MAX_W-1:0]       oy;
		logic                       fill;
		logic                       done;
	} crs_job_t;

endpackage

// ===== rtl/crs_queue.sv =====
// small job queue between the rasterizer front and back
// depends on crs_pkg
`timescale 1ns / 1ps

module crs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crs_pkg::crs_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output crs_pkg::crs_job_t head_job
);
	import crs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	crs_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

// ===== rtl/crs_front.sv =====
// rasterizer front: takes items, holds the circle state, runs the andres update
// depends on crs_pkg, feeds crs_queue
`timescale 1ns / 1ps

module crs_front #(
	parameter int RADIUS_BITS = crs_pkg::RADIUS_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic signed [crs_pkg::CENTER_W-1:0]  center_x,
	input  logic signed [crs_pkg::CENTER_W-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]               radius,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	input  logic                                 q_full,
	output logic                                 q_push,
	output crs_pkg::crs_job_t                    q_job
);
	import crs_pkg::*;

	localparam int DEC_W  = RADIUS_BITS + 3;
	localparam int WORK_W = RADIUS_BITS + 4;
	localparam logic signed [WORK_W-1:0] ONE_W = WORK_W'(1);
	localparam logic signed [DEC_W-1:0]  ONE_D = DEC_W'(1);

	logic                         active_q;
	logic                         fill_mode_q;
	logic signed [CENTER_W-1:0]   mid_x_q;
	logic signed [CENTER_W-1:0]   mid_y_q;
	logic [RADIUS_BITS-1:0]       rad_q;
	logic [RADIUS_BITS-1:0]       off_x_q;
	logic [RADIUS_BITS-1:0]       off_y_q;
	logic signed [DEC_W-1:0]      dec_q;

	logic                         accept;
	logic signed [WORK_W-1:0]     ox_e;
	logic signed [WORK_W-1:0]     oy_e;
	logic signed [WORK_W-1:0]     rad_e;
	logic signed [WORK_W-1:0]     d_e;
	logic signed [WORK_W-1:0]     two_ox;
	logic signed [WORK_W-1:0]     lim;
	logic signed [WORK_W-1:0]     nxt_d;
	logic signed [WORK_W-1:0]     nxt_ox;
	logic signed [WORK_W-1:0]     nxt_oy;
	logic                         done_w;
	logic signed [DEC_W-1:0]      rad_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign q_push    = accept && (cmd == CMD_STEP) && active_q;

	assign ox_e   = WORK_W'(off_x_q);
	assign oy_e   = WORK_W'(off_y_q);
	assign rad_e  = WORK_W'(rad_q);
	assign d_e    = WORK_W'(dec_q);
	assign two_ox = ox_e <<< 1;
	assign lim    = (rad_e - oy_e) <<< 1;
	assign rad_d  = DEC_W'(radius);

	// three-way andres update
	always_comb begin
		if (d_e >= two_ox) begin
			nxt_d  = d_e - two_ox - ONE_W;
			nxt_ox = ox_e + ONE_W;
			nxt_oy = oy_e;
		end else if (d_e < lim) begin
			nxt_d  = d_e + (oy_e <<< 1) - ONE_W;
			nxt_ox = ox_e;
			nxt_oy = oy_e - ONE_W;
		end else begin
			nxt_d  = d_e + ((oy_e - ox_e - ONE_W) <<< 1);
			nxt_ox = ox_e + ONE_W;
			nxt_oy = oy_e - ONE_W;
		end
	end

	assign done_w = (nxt_oy < nxt_ox);

	assign q_job.cx   = mid_x_q;
	assign q_job.cy   = mid_y_q;
	assign q_job.ox   = OFF_MAX_W'(off_x_q);
	assign q_job.oy   = OFF_MAX_W'(off_y_q);
	assign q_job.fill = fill_mode_q;
	assign q_job.done = done_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			fill_mode_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fill_mode_q <= cfg_data;
			end
			if (accept && (cmd == CMD_START)) begin
				active_q <= 1'b1;
			end else if (q_push && done_w) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_START)) begin
			mid_x_q <= center_x;
			mid_y_q <= center_y;
			rad_q   <= radius;
			off_x_q <= '0;
			off_y_q <= radius;
			dec_q   <= rad_d - ONE_D;
		end else if (q_push) begin
			off_x_q <= nxt_ox[RADIUS_BITS-1:0];
			off_y_q <= nxt_oy[RADIUS_BITS-1:0];
			dec_q   <= nxt_d[DEC_W-1:0];
		end
	end

endmodule

// ===== rtl/crs_back.sv =====
// rasterizer back: expands one queued step into points or spans, one beat a cycle while the output is not stalled
// depends on crs_pkg, reads crs_queue
`timescale 1ns / 1ps

module crs_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  crs_pkg::crs_job_t                   head_job,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [crs_pkg::COORD_W-1:0]  span_x_start,
	output logic signed [crs_pkg::COORD_W-1:0]  span_x_end,
	output logic signed [crs_pkg::COORD_W-1:0]  span_y,
	output logic                                last_of_step,
	output logic                                circle_done
);
	import crs_pkg::*;

	logic [IDX_W-1:0]           idx_q;
	logic                       out_valid_q;
	logic signed [COORD_W-1:0]  xs_q;
	logic signed [COORD_W-1:0]  xe_q;
	logic signed [COORD_W-1:0]  y_q;
	logic                       last_q;
	logic                       done_q;

	logic                       load;
	logic                       is_last;
	logic                       swap;
	logic                       xneg;
	logic                       yneg;
	logic signed [COORD_W-1:0]  cx17;
	logic signed [COORD_W-1:0]  cy17;
	logic signed [COORD_W-1:0]  ox17;
	logic signed [COORD_W-1:0]  oy17;
	logic signed [COORD_W-1:0]  a17;
	logic signed [COORD_W-1:0]  b17;
	logic signed [COORD_W-1:0]  x_plus;
	logic signed [COORD_W-1:0]  x_minus;
	logic signed [COORD_W-1:0]  y_val;

	assign load = head_valid && (!out_valid_q || !out_stall);

	assign cx17 = COORD_W'(head_job.cx);
	assign cy17 = COORD_W'(head_job.cy);
	assign ox17 = COORD_W'(head_job.ox);
	assign oy17 = COORD_W'(head_job.oy);

	// index bits pick the octant or the span row
	always_comb begin
		if (head_job.fill) begin
			swap    = ~(idx_q[0] ^ idx_q[1]);
			xneg    = 1'b0;
			yneg    = idx_q[1];
			is_last = (idx_q == FILL_LAST);
		end else begin
			swap    = idx_q[0];
			xneg    = idx_q[1];
			yneg    = idx_q[2];
			is_last = (idx_q == OUTLINE_LAST);
		end
	end

	assign a17     = swap ? oy17 : ox17;
	assign b17     = swap ? ox17 : oy17;
	assign x_plus  = cx17 + a17;
	assign x_minus = cx17 - a17;
	assign y_val   = yneg ? (cy17 - b17) : (cy17 + b17);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + IDX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (head_job.fill) begin
				xs_q <= x_minus;
				xe_q <= x_plus;
			end else begin
				xs_q <= xneg ? x_minus : x_plus;
				xe_q <= xneg ? x_minus : x_plus;
			end
			y_q    <= y_val;
			last_q <= is_last;
			done_q <= is_last && head_job.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign span_x_start = xs_q;
	assign span_x_end   = xe_q;
	assign span_y       = y_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

// ===== rtl/circle_span_rasterizer.sv =====
// circle span rasterizer top level: wires the front, the job queue and the back
// depends on crs_pkg, crs_front, crs_queue, crs_back, circle_span_rasterizer_assert.svh
//
// usage
//   input channel (in_valid / in_stall): cmd start loads center_x, center_y and
//     radius and emits nothing; cmd step emits the beats for the current offsets
//     and advances the circle one andres step. a step with no circle running is
//     swallowed without output.
//   config channel (cfg_valid / cfg_ready): cfg_data is fill_mode, always ready.
//     write it only while the block is drained.
//   output channel (out_valid / out_stall): one beat per cycle while not stalled,
//     eight outline points or four filled spans per step; last_of_step marks the
//     final beat of a step and circle_done the final beat of the circle.
//   the first beat of a step passes the queue write, then the back's output
//     register, before it is valid.
//   the back expands one step at a time through its single output register;
//     start items emit nothing.
//   the front takes items every cycle until the two-entry job queue is full,
//     so it keeps accepting while the back is busy or stalled.
//   out_stall holds the output register and the back; the queue then fills and
//     in_stall rises, nothing is dropped.
//   reset: no circle running, fill_mode cleared, queue and output empty.
`timescale 1ns / 1ps

module circle_span_rasterizer #(
	parameter int RADIUS_BITS = crs_pkg::RADIUS_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [crs_pkg::CENTER_W-1:0] center_x,
	input  logic signed [crs_pkg::CENTER_W-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]              radius,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [crs_pkg::COORD_W-1:0]  span_x_start,
	output logic signed [crs_pkg::COORD_W-1:0]  span_x_end,
	output logic signed [crs_pkg::COORD_W-1:0]  span_y,
	output logic                                last_of_step,
	output logic                                circle_done
);
	import crs_pkg::*;

	// front to queue
	logic     q_push;
	logic     q_full;
	crs_job_t q_job;

	// queue to back
	logic     q_pop;
	logic     q_head_valid;
	crs_job_t q_head_job;

	// front: circle state and the decision update, one step per accepted step item while a circle runs
	crs_front #(
		.RADIUS_BITS(RADIUS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	// job queue decouples the update from the beat expansion
	crs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_job  (q_head_job)
	);

	// back: walks the octants or span rows of the head job
	crs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.head_job    (q_head_job),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.span_x_start(span_x_start),
		.span_x_end  (span_x_end),
		.span_y      (span_y),
		.last_of_step(last_of_step),
		.circle_done (circle_done)
	);

`include "circle_span_rasterizer_assert.svh"

	// the front never writes a full queue
	`CRS_ASSERT_IMPLIES(a_no_push_full, q_push, !q_full)
	// the back only retires a job that is there
	`CRS_ASSERT_IMPLIES(a_pop_has_head, q_pop, q_head_valid)
	// a finished circle is only flagged on the final beat of its step
	`CRS_ASSERT_IMPLIES(a_done_is_last, out_valid && circle_done, last_of_step)
	// retiring a job always leaves a step-final beat in the output register
	`CRS_ASSERT_NEXT(a_pop_gives_last, q_pop, out_valid && last_of_step)

endmodule
